// ----- hw/rtl/d2p_pkg.sv -----
// shared constants, types and register codes for the disparity to point unit
// no dependencies
package d2p_pkg;

    localparam int D2P_DISP_LIMIT    = 96;
    localparam int D2P_REG_W         = 16;
    localparam int D2P_POS_W         = 12;
    localparam int D2P_DISP_W        = 12;
    localparam int D2P_COLOR_W       = 8;
    localparam int D2P_X_W           = 41;
    localparam int D2P_Y_W           = 48;
    localparam int D2P_Z_W           = 32;
    localparam int D2P_UD_W          = D2P_DISP_W - 1;
    localparam int D2P_NUM_W         = 48;
    localparam int D2P_DEN_W         = D2P_REG_W + D2P_UD_W;
    localparam int D2P_IDX_W         = 3;

    typedef enum logic [D2P_IDX_W-1:0] {
        REG_FOCAL_X  = 3'd0,
        REG_FOCAL_Y  = 3'd1,
        REG_CENTER_U = 3'd2,
        REG_CENTER_V = 3'd3,
        REG_BASELINE = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [D2P_POS_W-1:0]   column;
        logic [D2P_POS_W-1:0]   row;
        logic [D2P_COLOR_W-1:0] blue;
        logic [D2P_COLOR_W-1:0] green;
        logic [D2P_COLOR_W-1:0] red;
        logic                   y_sat;
    } t_side;

    localparam int D2P_SIDE_W = $bits(t_side);

endpackage

// ----- hw/rtl/d2p_if.sv -----
// stream interfaces for pixel words in and point words out
// depends on d2p_pkg
interface d2p_pixel_if
    import d2p_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic [D2P_POS_W-1:0]          column;
    logic [D2P_POS_W-1:0]          row;
    logic signed [D2P_DISP_W-1:0]  disparity;
    logic [D2P_COLOR_W-1:0]        blue;
    logic [D2P_COLOR_W-1:0]        green;
    logic [D2P_COLOR_W-1:0]        red;

    modport source (output valid, column, row, disparity, blue, green, red, input ready);
    modport sink   (input valid, column, row, disparity, blue, green, red, output ready);
endinterface

interface d2p_point_if
    import d2p_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [D2P_X_W-1:0]  point_x;
    logic signed [D2P_Y_W-1:0]  point_y;
    logic [D2P_Z_W-1:0]         point_z;
    logic [D2P_COLOR_W-1:0]     out_blue;
    logic [D2P_COLOR_W-1:0]     out_green;
    logic [D2P_COLOR_W-1:0]     out_red;
    logic [D2P_POS_W-1:0]       out_column;
    logic [D2P_POS_W-1:0]       out_row;

    modport source (output valid, point_x, point_y, point_z, out_blue, out_green, out_red,
                    out_column, out_row, input ready);
    modport sink   (input valid, point_x, point_y, point_z, out_blue, out_green, out_red,
                    out_column, out_row, output ready);
endinterface

// ----- hw/rtl/d2p_div_pipe.sv -----
// pipelined restoring divider, one quotient bit per stage, with sideband
// depends on d2p_pkg for default widths
module d2p_div_pipe
    import d2p_pkg::*;
#(
    parameter int NUM_W  = D2P_NUM_W,
    parameter int DEN_W  = D2P_DEN_W,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quot,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_vld  [NUM_W];
    logic [DEN_W-1:0]  r_rem  [NUM_W];
    logic [NUM_W-1:0]  r_nq   [NUM_W];
    logic [DEN_W-1:0]  r_den  [NUM_W];
    logic [SIDE_W-1:0] r_side [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic              p_vld;
        logic [DEN_W-1:0]  p_rem;
        logic [NUM_W-1:0]  p_nq;
        logic [DEN_W-1:0]  p_den;
        logic [SIDE_W-1:0] p_side;
        logic [DEN_W:0]    t;
        logic [DEN_W:0]    diff;
        logic              ge;
        logic [DEN_W-1:0]  n_rem;
        logic [NUM_W-1:0]  n_nq;

        if (k == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_rem  = '0;
            assign p_nq   = i_num;
            assign p_den  = i_den;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_nq   = r_nq[k-1];
            assign p_den  = r_den[k-1];
            assign p_side = r_side[k-1];
        end

        always_comb begin
            t     = {p_rem, p_nq[NUM_W-1]};
            diff  = t - {1'b0, p_den};
            ge    = (t >= {1'b0, p_den});
            n_rem = ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
            n_nq  = {p_nq[NUM_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_nq[k]   <= n_nq;
                r_den[k]  <= p_den;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_vld[NUM_W-1];
    assign o_quot  = r_nq[NUM_W-1];
    assign o_side  = r_side[NUM_W-1];

endmodule

// ----- hw/rtl/disparity_to_point_reprojection_unit.sv -----
// path from accepted pixel word to point word: two multiply stages,
// 48 divider stages (one quotient bit each) and the output register
// throughput one word per cycle; any output stall holds the whole pipeline
// synchronous active-low reset clears valid bits and loads the calibration defaults
// depends on d2p_pkg, d2p_if and d2p_div_pipe
module disparity_to_point_reprojection_unit
    import d2p_pkg::*;
#(
    parameter int DISP_LIMIT = D2P_DISP_LIMIT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [D2P_IDX_W-1:0]  i_cfg_idx,
    input  logic [D2P_REG_W-1:0]  i_cfg_data,
    d2p_pixel_if.sink             i_pix,
    d2p_point_if.source           o_pt
);

    localparam int DMAX = DISP_LIMIT * 16;

    logic [D2P_REG_W-1:0] r_fx, r_fy, r_u0, r_v0, r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx <= 16'd8000;
            r_fy <= 16'd8000;
            r_u0 <= 16'd5120;
            r_v0 <= 16'd3840;
            r_b  <= 16'd1920;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FOCAL_X:  r_fx <= i_cfg_data;
                REG_FOCAL_Y:  r_fy <= i_cfg_data;
                REG_CENTER_U: r_u0 <= i_cfg_data;
                REG_CENTER_V: r_v0 <= i_cfg_data;
                REG_BASELINE: r_b  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic r_out_valid;
    logic en;
    assign en = !r_out_valid || o_pt.ready;
    assign i_pix.ready = en;

    // stage 1: range check, offsets, first products
    logic signed [13:0]          d_ext;
    logic                        d_ok;
    logic signed [16:0]          xn, yn;
    logic [D2P_UD_W-1:0]         ud;

    always_comb begin
        d_ext = 14'(i_pix.disparity);
        d_ok  = (d_ext > 14'sd0) && (d_ext < $signed(14'(DMAX)));
        ud    = i_pix.disparity[D2P_UD_W-1:0];
        xn    = $signed({1'b0, i_pix.column, 4'b0}) - $signed({1'b0, r_u0});
        yn    = $signed({1'b0, i_pix.row, 4'b0}) - $signed({1'b0, r_v0});
    end

    logic                   r1_vld;
    logic [15:0]            r1_xmag, r1_ymag;
    logic                   r1_xneg, r1_yneg;
    logic [31:0]            r1_fb;
    logic [D2P_DEN_W-1:0]   r1_den, r1_ud;
    logic [D2P_REG_W-1:0]   r1_b;
    t_side                  r1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_pix.valid && d_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_xneg        <= xn[16];
            r1_yneg        <= yn[16];
            r1_xmag        <= xn[16] ? 16'(-xn) : xn[15:0];
            r1_ymag        <= yn[16] ? 16'(-yn) : yn[15:0];
            r1_fb          <= r_fx * r_b;
            r1_den         <= r_fy * ud;
            r1_ud          <= D2P_DEN_W'(ud);
            r1_b           <= r_b;
            r1_side.column <= i_pix.column;
            r1_side.row    <= i_pix.row;
            r1_side.blue   <= i_pix.blue;
            r1_side.green  <= i_pix.green;
            r1_side.red    <= i_pix.red;
            r1_side.y_sat  <= 1'b0;
        end
    end

    // stage 2: numerators and y divisor fixup
    logic                   r2_vld;
    logic [D2P_NUM_W-1:0]   r2_xp, r2_yp, r2_zp;
    logic [D2P_DEN_W-1:0]   r2_yden, r2_ud;
    logic                   r2_xneg, r2_yneg;
    t_side                  r2_side;
    logic [D2P_NUM_W-1:0]   yp;
    logic [31:0]            xp;
    logic                   den0;
    t_side                  n2_side;

    always_comb begin
        yp   = r1_ymag * r1_fb;
        xp   = r1_xmag * r1_b;
        den0 = (r1_den == '0);
        n2_side       = r1_side;
        n2_side.y_sat = den0 && (yp != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_xp         <= D2P_NUM_W'(xp);
            r2_yp         <= yp;
            r2_zp         <= D2P_NUM_W'(r1_fb);
            r2_yden       <= den0 ? D2P_DEN_W'(1) : r1_den;
            r2_ud         <= r1_ud;
            r2_xneg       <= r1_xneg;
            r2_yneg       <= r1_yneg;
            r2_side       <= n2_side;
        end
    end

    // dividers
    logic                   dx_vld, dy_vld, dz_vld;
    logic [D2P_NUM_W-1:0]   qx, qy, qz;
    logic                   dx_neg, dz_neg;
    t_side                  dy_side;

    d2p_div_pipe #(.NUM_W(D2P_NUM_W), .DEN_W(D2P_DEN_W), .SIDE_W(1)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r2_vld),
        .i_num(r2_xp), .i_den(r2_ud), .i_side(r2_xneg),
        .o_valid(dx_vld), .o_quot(qx), .o_side(dx_neg)
    );

    d2p_div_pipe #(.NUM_W(D2P_NUM_W), .DEN_W(D2P_DEN_W), .SIDE_W(D2P_SIDE_W)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r2_vld),
        .i_num(r2_yp), .i_den(r2_yden), .i_side(r2_side),
        .o_valid(dy_vld), .o_quot(qy), .o_side(dy_side)
    );

    // z lane carries the y sign
    d2p_div_pipe #(.NUM_W(D2P_NUM_W), .DEN_W(D2P_DEN_W), .SIDE_W(1)) u_div_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r2_vld),
        .i_num(r2_zp), .i_den(r2_ud), .i_side(r2_yneg),
        .o_valid(dz_vld), .o_quot(qz), .o_side(dz_neg)
    );

    // saturation and output register
    localparam logic [D2P_NUM_W-1:0] X_HALF = D2P_NUM_W'(1) << (D2P_X_W - 1);
    localparam logic [D2P_NUM_W-1:0] Y_HALF = D2P_NUM_W'(1) << (D2P_Y_W - 1);

    logic [D2P_NUM_W-1:0]   xm, ym, xs, ys;
    logic [D2P_X_W-1:0]     n_x;
    logic [D2P_Y_W-1:0]     n_y;

    always_comb begin
        xm = qx;
        ym = dy_side.y_sat ? '1 : qy;
        if (dx_neg && xm != '0) begin
            xs  = (xm > X_HALF) ? X_HALF : xm;
            n_x = D2P_X_W'(-xs);
        end else begin
            xs  = (xm > X_HALF - 1) ? X_HALF - 1 : xm;
            n_x = D2P_X_W'(xs);
        end
        if (dz_neg && ym != '0) begin
            ys  = (ym > Y_HALF) ? Y_HALF : ym;
            n_y = D2P_Y_W'(-ys);
        end else begin
            ys  = (ym > Y_HALF - 1) ? Y_HALF - 1 : ym;
            n_y = D2P_Y_W'(ys);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dx_vld && dy_vld && dz_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_pt.point_x    <= n_x;
            o_pt.point_y    <= n_y;
            o_pt.point_z    <= qz[D2P_Z_W-1:0];
            o_pt.out_blue   <= dy_side.blue;
            o_pt.out_green  <= dy_side.green;
            o_pt.out_red    <= dy_side.red;
            o_pt.out_column <= dy_side.column;
            o_pt.out_row    <= dy_side.row;
        end
    end

    assign o_pt.valid = r_out_valid;

endmodule
